[rtl/drrip_pkg.sv]
// ----------------------------------------------------------------------------
// DRRIP cache lookup package
// Shared constants for the DRRIP tag array.
// ----------------------------------------------------------------------------
`default_nettype none
package drrip_pkg;
  localparam int ADDR_W = 48;
  localparam int BLOCK_W = 42;
  localparam int LINE_SHIFT = 6;
  localparam int DEF_NUM_SETS = 2048;
  localparam int DEF_NUM_WAYS = 16;
  localparam int DEF_NUM_BANKS = 8;
  localparam int DEF_RRPV_BITS = 2;
  localparam int DEF_PSEL_BITS = 10;
  localparam logic [47:0] LCG_MUL = 48'h5_DEEC_E66D;
  localparam logic [47:0] LCG_ADD = 48'hB;
  localparam logic [15:0] LCG_SEED_LOW = 16'h330E;
  localparam int DUEL_GROUPS = 32;
  localparam logic [1:0] KIND_FOLLOW = 2'd0;
  localparam logic [1:0] KIND_SRRIP = 2'd1;
  localparam logic [1:0] KIND_BRRIP = 2'd2;
endpackage
`default_nettype wire

[rtl/drrip_if.sv]
// ----------------------------------------------------------------------------
// DRRIP channel interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface drrip_req_if;
  logic valid;
  logic ready;
  logic [47:0] byte_address;
  logic is_write;
  logic allocate;
  modport source (output valid, output byte_address, output is_write, output allocate,
                  input ready);
  modport sink (input valid, input byte_address, input is_write, input allocate,
                output ready);
endinterface

interface drrip_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  logic writeback;
  logic evicted_valid;
  logic [41:0] evicted_block;
  modport source (output valid, output hit, output writeback, output evicted_valid,
                  output evicted_block, input ready);
  modport sink (input valid, input hit, input writeback, input evicted_valid,
                input evicted_block, output ready);
endinterface
`default_nettype wire

[rtl/drrip_hash.sv]
// ----------------------------------------------------------------------------
// DRRIP set hash
// Two-stage drand48 step from block number to set index.
// ----------------------------------------------------------------------------
`default_nettype none
module drrip_hash #(
  parameter int SET_W = $clog2(drrip_pkg::DEF_NUM_SETS)
) (
  input  wire logic clk,
  input  wire logic [41:0] block,
  input  wire logic en,
  output logic [SET_W-1:0] set_idx
);
  logic [47:0] seed;
  logic [47:0] part_lo_r;
  logic [23:0] part_hi_r;
  logic [47:0] prod;

  assign seed = {block[31:0], drrip_pkg::LCG_SEED_LOW};

  always_ff @(posedge clk) begin
    if (en) begin
      part_lo_r <= {24'd0, seed[23:0]} * {12'd0, drrip_pkg::LCG_MUL[35:0]};
      part_hi_r <= seed[47:24] * drrip_pkg::LCG_MUL[23:0];
    end
  end

  assign prod = part_lo_r + {part_hi_r, 24'd0} + drrip_pkg::LCG_ADD;
  assign set_idx = prod[16 +: SET_W];
endmodule
`default_nettype wire

[rtl/drrip_set_assoc_cache_lookup.sv]
// ----------------------------------------------------------------------------
// DRRIP set-associative cache lookup
// Tag array of a last-level cache with DRRIP replacement and set dueling.
// ----------------------------------------------------------------------------
// Each item passes through the states HASH, READ and UPD after acceptance: in
// HASH the set hash completes and the set is read from memory, in READ the row
// sits in a register, and in UPD hit, victim and insertion are resolved while
// the set is written back if the access changes it and the result is registered.
// The next item is accepted only in IDLE after UPD, so items never overlap.
// An item may be accepted while the previous result still waits; the
// update stage then holds until the output register is free. Line state is
// kept in one set-wide memory whose reset contents are set by a clearing pass
// over all NUM_SETS rows after reset, one row per cycle, before the first item.
`default_nettype none
module drrip_set_assoc_cache_lookup #(
  parameter int NUM_SETS = drrip_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS = drrip_pkg::DEF_NUM_WAYS,
  parameter int NUM_BANKS = drrip_pkg::DEF_NUM_BANKS,
  parameter int RRPV_BITS = drrip_pkg::DEF_RRPV_BITS,
  parameter int PSEL_BITS = drrip_pkg::DEF_PSEL_BITS
) (
  input wire logic clk,
  input wire logic rst_n,
  drrip_req_if.sink in_req,
  drrip_rsp_if.source out_rsp
);
  localparam int SET_W = $clog2(NUM_SETS);
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int DSIZE = NUM_SETS / drrip_pkg::DUEL_GROUPS;
  localparam int DSZ_W = $clog2(DSIZE);
  localparam logic [RRPV_BITS-1:0] RMAX = {RRPV_BITS{1'b1}};
  localparam logic [PSEL_BITS-1:0] PMAX = {PSEL_BITS{1'b1}};
  localparam logic [PSEL_BITS-1:0] PMID = PSEL_BITS'(1) << (PSEL_BITS - 1);
  localparam logic [2:0] ST_CLR = 3'd0, ST_IDLE = 3'd1, ST_HASH = 3'd2,
    ST_READ = 3'd3, ST_UPD = 3'd4;

  typedef struct packed {
    logic v;
    logic d;
    logic [RRPV_BITS-1:0] rrpv;
    logic [drrip_pkg::BLOCK_W-1:0] tag;
  } line_t;

  localparam line_t CLR_LINE = '{v: 1'b0, d: 1'b0, rrpv: RMAX, tag: '0};

  line_t [NUM_WAYS-1:0] mem [NUM_SETS];
  line_t [NUM_WAYS-1:0] rd_r;
  line_t [NUM_WAYS-1:0] wr_data;

  logic [2:0] state_r, state_nxt;
  logic [SET_W-1:0] clr_r;
  logic [41:0] block_r;
  logic wr_r, alloc_r;
  logic [SET_W-1:0] set_idx, set_r;
  logic [PSEL_BITS-1:0] psel_r [NUM_BANKS];
  logic [4:0] mcount_r;
  logic out_valid_r, hit_r, wb_r, ev_r;
  logic [41:0] evb_r;
  logic mem_we;
  logic [SET_W-1:0] mem_addr;
  logic upd_go;

  drrip_hash #(.SET_W(SET_W)) u_hash (
    .clk(clk), .block(in_req.byte_address[47:6]),
    .en(in_req.valid && in_req.ready), .set_idx(set_idx));

  assign in_req.ready = (state_r == ST_IDLE);
  assign upd_go = (state_r == ST_UPD) && (!out_valid_r || out_rsp.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: if (clr_r == SET_W'(NUM_SETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (in_req.valid && in_req.ready) state_nxt = ST_HASH;
      ST_HASH: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_UPD;
      ST_UPD: if (upd_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  // Lookup, victim selection, insertion and set update on the read set.
  logic hit_c;
  logic [WAY_W-1:0] hway, inv_way, max_way, victim;
  logic inv_found;
  logic [RRPV_BITS-1:0] top, delta, ins;
  logic [1:0] kind;
  logic [DSZ_W:0] c_idx;
  logic [DSZ_W-1:0] o_idx, b_idx;
  logic [BANK_W-1:0] bank;
  logic brrip;
  logic [RRPV_BITS-1:0] aged [NUM_WAYS];

  assign bank = (NUM_BANKS > 1) ? BANK_W'(block_r % NUM_BANKS) : '0;
  assign c_idx = (DSZ_W+1)'(set_r >> DSZ_W);
  assign o_idx = set_r[DSZ_W-1:0];
  assign b_idx = ~o_idx;

  always_comb begin
    hit_c = 1'b0; hway = '0; inv_found = 1'b0; inv_way = '0; top = '0;
    max_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rd_r[w].v && rd_r[w].tag == block_r) begin
        hit_c = 1'b1; hway = WAY_W'(w);
      end
      if (!rd_r[w].v) begin
        inv_found = 1'b1; inv_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++)
      if (rd_r[w].rrpv > top) top = rd_r[w].rrpv;
    delta = RMAX - top;
    for (int w = 0; w < NUM_WAYS; w++) aged[w] = rd_r[w].rrpv + delta;
    for (int w = NUM_WAYS - 1; w >= 0; w--)
      if (rd_r[w].rrpv == top) begin
        max_way = WAY_W'(w);
      end
    victim = inv_found ? inv_way : max_way;
    if (c_idx == (DSZ_W+1)'(o_idx)) kind = drrip_pkg::KIND_SRRIP;
    else if (c_idx == (DSZ_W+1)'(b_idx)) kind = drrip_pkg::KIND_BRRIP;
    else kind = drrip_pkg::KIND_FOLLOW;
    unique case (kind)
      drrip_pkg::KIND_SRRIP: brrip = 1'b0;
      drrip_pkg::KIND_BRRIP: brrip = 1'b1;
      default: brrip = psel_r[bank] > PMID;
    endcase
    ins = (brrip && mcount_r != 5'd0) ? RMAX : RMAX - RRPV_BITS'(1);
    wr_data = rd_r;
    if (hit_c) begin
      if (alloc_r) wr_data[hway].rrpv = '0;
      if (wr_r) wr_data[hway].d = 1'b1;
    end else begin
      if (!inv_found)
        for (int w = 0; w < NUM_WAYS; w++) wr_data[w].rrpv = aged[w];
      wr_data[victim].rrpv = ins;
      wr_data[victim].tag = block_r;
      wr_data[victim].v = 1'b1;
      wr_data[victim].d = wr_r;
    end
  end

  assign mem_we = (state_r == ST_CLR) ||
    (upd_go && (hit_c ? (alloc_r || wr_r) : alloc_r));
  assign mem_addr = (state_r == ST_CLR) ? clr_r : set_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      if (state_r == ST_CLR)
        mem[mem_addr] <= {NUM_WAYS{CLR_LINE}};
      else
        mem[mem_addr] <= wr_data;
    end
    if (state_r == ST_HASH) rd_r <= mem[set_idx];
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      block_r <= in_req.byte_address[47:6];
      wr_r <= in_req.is_write;
      alloc_r <= in_req.allocate;
    end
    if (state_r == ST_HASH) set_r <= set_idx;
    if (upd_go) begin
      hit_r <= hit_c;
      wb_r <= !hit_c && alloc_r && !inv_found && rd_r[victim].d;
      ev_r <= !hit_c && alloc_r && !inv_found;
      evb_r <= (!hit_c && alloc_r && !inv_found) ? rd_r[victim].tag : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      mcount_r <= '0;
      for (int b = 0; b < NUM_BANKS; b++) psel_r[b] <= PMID;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_r <= clr_r + SET_W'(1);
      if (upd_go) out_valid_r <= 1'b1;
      else if (out_rsp.ready) out_valid_r <= 1'b0;
      if (upd_go && !hit_c && alloc_r) begin
        mcount_r <= mcount_r + 5'd1;
        if (kind == drrip_pkg::KIND_SRRIP && psel_r[bank] != PMAX)
          psel_r[bank] <= psel_r[bank] + PSEL_BITS'(1);
        else if (kind == drrip_pkg::KIND_BRRIP && psel_r[bank] != '0)
          psel_r[bank] <= psel_r[bank] - PSEL_BITS'(1);
      end
    end
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.hit = hit_r;
  assign out_rsp.writeback = wb_r;
  assign out_rsp.evicted_valid = ev_r;
  assign out_rsp.evicted_block = evb_r;

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLR |-> !in_req.ready) else $error("accept during clear");
  a_wb_needs_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && wb_r |-> ev_r && !hit_r) else $error("writeback without eviction");
  a_result_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |=> out_valid_r) else $error("result missing");
endmodule
`default_nettype wire

[dv/drrip_set_assoc_cache_lookup_tb.sv]
// ----------------------------------------------------------------------------
// DRRIP cache lookup testbench
// Drives random and directed accesses through the request channel, predicts
// hit, writeback and eviction with a behavioral copy of the tag array, and
// compares every result item in order.
// ----------------------------------------------------------------------------
module drrip_set_assoc_cache_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS = drrip_pkg::DEF_NUM_SETS;
  localparam int WAYS = drrip_pkg::DEF_NUM_WAYS;
  localparam int BANKS = drrip_pkg::DEF_NUM_BANKS;
  localparam int RMAX = (1 << drrip_pkg::DEF_RRPV_BITS) - 1;
  localparam int PMAX = (1 << drrip_pkg::DEF_PSEL_BITS) - 1;
  localparam int PMID = 1 << (drrip_pkg::DEF_PSEL_BITS - 1);
  localparam int LINES = SETS * WAYS;
  localparam int STALL_LIMIT = 4 * SETS + 2000;

  typedef struct packed {
    logic [47:0] addr;
    logic wr;
    logic alloc;
  } access_t;

  typedef struct packed {
    logic hit;
    logic wb;
    logic ev;
    logic [41:0] blk;
  } lookup_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  drrip_req_if in_req();
  drrip_rsp_if out_rsp();

  drrip_set_assoc_cache_lookup uut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source)
  );

  always #6 clk = ~clk;

  logic [41:0] tags [LINES];
  bit valid_m [LINES];
  bit dirty_m [LINES];
  int rrpv_m [LINES];
  int psel [BANKS];
  int miss_cnt;

  access_t pending_q [$];
  lookup_t expected_q [$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 0;
  bit in_took = 0;
  bit out_took = 0;

  // Recent blocks, reused to produce hits and set conflicts.
  logic [41:0] hot_blocks [$];

  function automatic void add_pending(access_t a);
    pending_q = {pending_q, a};
  endfunction

  function automatic void add_expected(lookup_t r);
    expected_q = {expected_q, r};
  endfunction

  function automatic void add_hot(logic [41:0] b);
    hot_blocks = {hot_blocks, b};
  endfunction

  function automatic int set_index(logic [41:0] blk);
    logic [47:0] s;
    s = {blk[31:0], drrip_pkg::LCG_SEED_LOW};
    s = drrip_pkg::LCG_MUL * s + drrip_pkg::LCG_ADD;
    return int'(s[47:16] % SETS);
  endfunction

  function automatic int duel_class(int st);
    int sz, c, o;
    sz = SETS / drrip_pkg::DUEL_GROUPS;
    if (sz == 0) return int'(drrip_pkg::KIND_FOLLOW);
    c = st / sz;
    o = st % sz;
    if (c == o) return int'(drrip_pkg::KIND_SRRIP);
    if (c == int'((32'hFFFF_FFFF - o) % sz)) return int'(drrip_pkg::KIND_BRRIP);
    return int'(drrip_pkg::KIND_FOLLOW);
  endfunction

  function automatic lookup_t predict_lookup(access_t a);
    lookup_t r;
    logic [41:0] blk;
    int st, bank, base, victim, top, kind;
    bit found, brrip;
    r = '0;
    blk = a.addr[47:6];
    st = set_index(blk);
    bank = int'(blk % BANKS);
    base = st * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_m[base+w] && tags[base+w] == blk) begin
        if (a.alloc) rrpv_m[base+w] = 0;
        if (a.wr) dirty_m[base+w] = 1;
        r.hit = 1;
        return r;
      end
    end
    if (!a.alloc) return r;
    kind = duel_class(st);
    if (kind == int'(drrip_pkg::KIND_SRRIP)) begin
      brrip = 0;
      if (psel[bank] < PMAX) psel[bank]++;
    end else if (kind == int'(drrip_pkg::KIND_BRRIP)) begin
      brrip = 1;
      if (psel[bank] > 0) psel[bank]--;
    end else begin
      brrip = psel[bank] > PMID;
    end
    found = 0;
    victim = 0;
    for (int w = 0; w < WAYS && !found; w++)
      if (!valid_m[base+w]) begin
        victim = w;
        found = 1;
      end
    if (!found) begin
      top = 0;
      for (int w = 0; w < WAYS; w++) if (rrpv_m[base+w] > top) top = rrpv_m[base+w];
      if (top < RMAX)
        for (int w = 0; w < WAYS; w++) rrpv_m[base+w] += RMAX - top;
      for (int w = 0; w < WAYS && !found; w++)
        if (rrpv_m[base+w] == RMAX) begin
          victim = w;
          found = 1;
        end
      r.wb = dirty_m[base+victim];
      r.ev = 1;
      r.blk = tags[base+victim];
    end
    rrpv_m[base+victim] = (brrip && miss_cnt != 0) ? RMAX : RMAX - 1;
    tags[base+victim] = blk;
    valid_m[base+victim] = 1;
    dirty_m[base+victim] = a.wr;
    miss_cnt = (miss_cnt + 1) % 32;
    return r;
  endfunction

  // Random block that lands in set st, searched by rejection.
  function automatic logic [41:0] block_in_set(int st);
    logic [41:0] b;
    do b = 42'({$urandom, $urandom}); while (set_index(b) != st);
    return b;
  endfunction

  function automatic access_t make_access(logic [41:0] blk, bit wr, bit alloc);
    access_t a;
    a.addr = {blk, 6'($urandom)};
    a.wr = wr;
    a.alloc = alloc;
    return a;
  endfunction

  initial begin
    access_t a;
    logic [41:0] b;
    int st, sz;
    for (int i = 0; i < LINES; i++) begin
      tags[i] = '0;
      valid_m[i] = 0;
      dirty_m[i] = 0;
      rrpv_m[i] = RMAX;
    end
    for (int i = 0; i < BANKS; i++) psel[i] = PMID;
    miss_cnt = 0;
    sz = SETS / drrip_pkg::DUEL_GROUPS;

    add_pending('{48'h0, 1'b0, 1'b0});
    add_pending('{48'h0, 1'b1, 1'b1});
    add_pending('{48'h3F, 1'b0, 1'b0});
    add_pending('{48'hFFFF_FFFF_FFFF, 1'b1, 1'b0});
    add_pending('{48'hFFFF_FFFF_FFFF, 1'b0, 1'b1});
    add_pending('{48'hFFFF_FFFF_FFC0, 1'b1, 1'b1});
    add_pending('{48'hFFFF_FFFF_FFC0, 1'b0, 1'b1});
    // Overfill one dedicated set so that dirty lines are evicted.
    for (int i = 0; i < WAYS + 3; i++)
      add_pending(make_access(block_in_set(0), 1'b1, 1'b1));

    while (pending_q.size() < 1570) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30 && hot_blocks.size() > 0) begin
        b = hot_blocks[$urandom_range(0, hot_blocks.size() - 1)];
      end else if (pick < 75) begin
        case ($urandom_range(0, 2))
          0: st = $urandom_range(0, drrip_pkg::DUEL_GROUPS - 1) * (sz + 1);
          1: st = $urandom_range(0, 7) * 3;
          default: st = $urandom_range(0, SETS - 1);
        endcase
        if (st >= SETS) st = st % SETS;
        b = block_in_set(st);
        add_hot(b);
        if (hot_blocks.size() > 64) void'(hot_blocks.pop_front());
      end else begin
        b = 42'({$urandom, $urandom});
      end
      a = make_access(b, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
      add_pending(a);
    end
    stim_done = 1;
  end

  int send_wait = 0;
  int recv_wait = 0;
  int rst_cnt = 0;

  always @(negedge clk) begin
    if (rst_cnt < 11) begin
      rst_cnt <= rst_cnt + 1;
      rst_n <= (rst_cnt + 1 >= 11);
    end
  end

  initial begin
    in_req.valid = 1'b0;
    in_req.byte_address = '0;
    in_req.is_write = 1'b0;
    in_req.allocate = 1'b0;
    out_rsp.ready = 1'b0;
  end

  always @(negedge clk) begin
    bit hold;
    if (rst_n) begin
      hold = in_req.valid && !in_took;
      if (in_took) begin
        in_took = 1'b0;
        void'(pending_q.pop_front());
        send_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 4) == 0) send_wait = 0;
      end
      if (hold) begin
      end else if (send_wait > 0) begin
        send_wait--;
        in_req.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_req.valid <= 1'b1;
        in_req.byte_address <= pending_q[0].addr;
        in_req.is_write <= pending_q[0].wr;
        in_req.allocate <= pending_q[0].alloc;
      end else begin
        in_req.valid <= 1'b0;
      end
      if (out_took) begin
        out_took = 1'b0;
        recv_wait = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    lookup_t got, exp_r;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_req.valid && in_req.ready) begin
        add_expected(predict_lookup('{in_req.byte_address, in_req.is_write,
                                      in_req.allocate}));
        in_took = 1'b1;
        moved = 1'b1;
      end
      if (out_rsp.valid && out_rsp.ready) begin
        out_took = 1'b1;
        moved = 1'b1;
        got = '{out_rsp.hit, out_rsp.writeback, out_rsp.evicted_valid,
                out_rsp.evicted_block};
        if (expected_q.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.hit !== exp_r.hit) begin
            $error("hit expected %0h actual %0h", exp_r.hit, got.hit);
            errors++;
          end
          if (got.wb !== exp_r.wb) begin
            $error("writeback expected %0h actual %0h", exp_r.wb, got.wb);
            errors++;
          end
          if (got.ev !== exp_r.ev) begin
            $error("evicted_valid expected %0h actual %0h", exp_r.ev, got.ev);
            errors++;
          end
          if (got.blk !== exp_r.blk) begin
            $error("evicted_block expected %0h actual %0h", exp_r.blk, got.blk);
            errors++;
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while ((pending_q.size() > 0 || expected_q.size() > 0 || in_req.valid)
           && idle_cycles < STALL_LIMIT)
      @(posedge clk);
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      if (errors == 0 && expected_q.size() == 0) begin
        $display("TB_OK");
      end else begin
        $display("TB_ERROR");
      end
      $finish;
    end
  end
endmodule
